@@ hdl/srd_pkg.sv @@
// Shared types and constants for the sorted id set with range delete.
`timescale 1ns / 1ps
`default_nettype none
package srd_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = 7;
	localparam int ID_W     = 32;
	localparam int STAT_W   = 3;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STAT_W-1:0] ST_PRESENT  = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd3;
	localparam logic [STAT_W-1:0] ST_NONE     = 3'd4;

	typedef struct packed {
		logic            req_type;
		logic [ID_W-1:0] key_id;
		logic [ID_W-1:0] range_end;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   removed_id;
		logic [CNT_W-1:0]  entries_left;
		logic              last;
	} res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
	} stat_t;

endpackage
`default_nettype wire

@@ hdl/srd_ctrl.sv @@
// Controller state machine: load, scan the store, finish the request.
`timescale 1ns / 1ps
`default_nettype none
module srd_ctrl
	import srd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		busy       = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/srd_dpath.sv @@
// Datapath: id store, scan pipeline, insert shift, range compaction and result register.
`timescale 1ns / 1ps
`default_nettype none
module srd_dpath
	import srd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire req_t request,
	output stat_t     stat,
	output logic      result_valid,
	output res_t      result
);

	logic [ID_W-1:0] mem [CAPACITY];

	logic [CNT_W-1:0]  count_q;
	logic              req_q;
	logic [ID_W-1:0]   key_q;
	logic [ID_W-1:0]   end_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              dv_s1;
	logic [ID_W-1:0]   rd_data_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic              placed_q;
	logic              present_q;
	logic [ID_W-1:0]   carry_q;
	logic [CNT_W-1:0]  keep_q;
	logic              pend_vld_q;
	logic [ID_W-1:0]   pend_q;
	logic [CNT_W-1:0]  left_q;
	logic              out_vld_q;
	res_t              out_q;

	logic              rd_en;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ID_W-1:0]   wr_data;
	logic              full;
	logic              is_eq;
	logic              is_gt;
	logic              in_rng;
	logic              ins_first;
	logic              ins_shift;
	logic              step;

	assign full      = (count_q == CNT_W'(CAPACITY));
	assign is_eq     = (rd_data_s1 == key_q);
	assign is_gt     = (rd_data_s1 > key_q);
	assign in_rng    = (rd_data_s1 >= key_q) && (rd_data_s1 < end_q);
	assign ins_first = !present_q && !placed_q && is_gt;
	assign ins_shift = !present_q && placed_q;
	assign step      = cmd.scan && dv_s1;
	assign rd_en     = cmd.scan && (rd_idx_q != count_q);

	assign stat.scan_done = (rd_idx_q == count_q) && !dv_s1;
	assign result_valid   = out_vld_q;
	assign result         = out_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = rd_data_s1;
		if (step) begin
			if (req_q == REQ_INSERT) begin
				if (!full && (ins_first || ins_shift)) begin
					wr_en   = 1'b1;
					wr_data = ins_first ? key_q : carry_q;
				end
			end else if (!in_rng) begin
				// compact kept ids down over the removed ones
				wr_en   = 1'b1;
				wr_addr = keep_q[ADDR_W-1:0];
			end
		end else if (cmd.finish && (req_q == REQ_INSERT) && !present_q && !full) begin
			wr_en   = 1'b1;
			wr_addr = count_q[ADDR_W-1:0];
			wr_data = placed_q ? carry_q : key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx_q[ADDR_W-1:0]];
			idx_s1     <= rd_idx_q[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_idx_q  <= '0;
			dv_s1     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= cmd.finish ||
				(step && (req_q == REQ_REMOVE) && in_rng && pend_vld_q);
			if (cmd.load) begin
				rd_idx_q <= '0;
				dv_s1    <= 1'b0;
			end else if (cmd.scan) begin
				dv_s1 <= rd_en;
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
			end
			if (cmd.finish) begin
				if (req_q == REQ_INSERT) begin
					if (!present_q && !full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end else begin
					count_q <= keep_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q      <= request.req_type;
			key_q      <= request.key_id;
			end_q      <= request.range_end;
			placed_q   <= 1'b0;
			present_q  <= 1'b0;
			keep_q     <= '0;
			pend_vld_q <= 1'b0;
			left_q     <= count_q;
		end
		if (step) begin
			if (req_q == REQ_INSERT) begin
				if (!present_q && is_eq) begin
					present_q <= 1'b1;
				end
				if (ins_first) begin
					placed_q <= 1'b1;
					carry_q  <= rd_data_s1;
				end else if (ins_shift) begin
					carry_q <= rd_data_s1;
				end
			end else if (in_rng) begin
				// hold each match until the next one shows it was not the last
				if (pend_vld_q) begin
					out_q.status       <= ST_REMOVED;
					out_q.removed_id   <= pend_q;
					out_q.entries_left <= left_q - CNT_W'(1);
					out_q.last         <= 1'b0;
					left_q             <= left_q - CNT_W'(1);
				end
				pend_q     <= rd_data_s1;
				pend_vld_q <= 1'b1;
			end else begin
				keep_q <= keep_q + CNT_W'(1);
			end
		end
		if (cmd.finish) begin
			out_q.last <= 1'b1;
			if (req_q == REQ_INSERT) begin
				out_q.removed_id <= '0;
				priority if (present_q) begin
					out_q.status       <= ST_PRESENT;
					out_q.entries_left <= count_q;
				end else if (full) begin
					out_q.status       <= ST_FULL;
					out_q.entries_left <= count_q;
				end else begin
					out_q.status       <= ST_INSERTED;
					out_q.entries_left <= count_q + CNT_W'(1);
				end
			end else if (pend_vld_q) begin
				out_q.status       <= ST_REMOVED;
				out_q.removed_id   <= pend_q;
				out_q.entries_left <= keep_q;
			end else begin
				out_q.status       <= ST_NONE;
				out_q.removed_id   <= '0;
				out_q.entries_left <= keep_q;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("held id count above capacity");

	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> rd_idx_q <= count_q)
		else $error("scan index ran past the held ids");

	a_last_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.last |-> $past(cmd.finish))
		else $error("final result outside the finish step");

	a_keep_behind: assert property (@(posedge clk) disable iff (!arst_n)
		step && (req_q == REQ_REMOVE) |-> keep_q <= CNT_W'(idx_s1))
		else $error("compaction write overtook the scan");

endmodule
`default_nettype wire

@@ hdl/sorted_id_set_range_delete.sv @@
// Top level of the sorted id set with range delete.
// Holds up to CAPACITY (64) unique 32-bit ids in ascending order in a single
// memory with one read and one write port. A request is taken when start is
// high and busy is low; busy stays high until the request is complete. Every
// request walks the held ids once, one entry per cycle through the read port.
// A request is loaded, then the store is streamed through the registered
// read and the last entry is let settle, then the request is finished. An
// insert gives one result at its end. A remove gives one result per deleted
// id, in ascending order, during the walk and at its end, with last set on
// the final one; a remove that deletes nothing gives a single result.
// Results appear on result for one cycle with result_valid high and cannot
// be held off, so the receiver must take them as they come. No clearing
// pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module sorted_id_set_range_delete
	import srd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t request,
	output logic      result_valid,
	output res_t      result
);

	cmd_t  cmd;
	stat_t stat;

	srd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	srd_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.request      (request),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
`default_nettype wire
